@@ hw/rtl/md5_pkg.sv @@
package md5_pkg;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       has_byte;
		logic       last;
	} req_t;

	typedef struct packed {
		logic [63:0] digest_low;
		logic [63:0] digest_high;
	} rsp_t;

	typedef logic [3:0] step_t;
	typedef logic [5:0] round_t;

	typedef enum logic [2:0] {
		W_NONE,
		W_BYTE,
		W_PAD,
		W_CLEAR_LEN,
		W_LEN
	} wop_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_STAY_IDLE,
		C_NOT_FULL,
		C_ROUND_MORE,
		C_NOT_LAST,
		C_LEN_FITS,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		logic  accept;
		wop_t  wop;
		logic  load_abcd;
		logic  round;
		logic  chain_add;
		logic  emit;
		cond_t cond;
		step_t target;
	} ctl_t;

	localparam step_t STEP_IDLE       = 4'd0;
	localparam step_t STEP_FULL_INIT  = 4'd1;
	localparam step_t STEP_FULL_ROUND = 4'd2;
	localparam step_t STEP_FULL_ADD   = 4'd3;
	localparam step_t STEP_PAD        = 4'd4;
	localparam step_t STEP_XTRA_ROUND = 4'd5;
	localparam step_t STEP_XTRA_ADD   = 4'd6;
	localparam step_t STEP_XTRA_CLEAR = 4'd7;
	localparam step_t STEP_LEN        = 4'd8;
	localparam step_t STEP_LAST_ROUND = 4'd9;
	localparam step_t STEP_LAST_ADD   = 4'd10;
	localparam step_t STEP_EMIT       = 4'd11;
	localparam step_t STEP_DONE       = 4'd12;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0]  PAD_MARK  = 8'h80;
	localparam round_t      ROUND_MAX = 6'd63;
	localparam logic [5:0]  LEN_LIMIT = 6'd56;

	localparam logic [31:0] K_TAB [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] S_TAB [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22,
		5'd5, 5'd9,  5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23,
		5'd6, 5'd10, 5'd15, 5'd21
	};

	function automatic logic [4:0] md5_s(input round_t r);
		return S_TAB[{r[5:4], r[1:0]}];
	endfunction

	function automatic logic [3:0] md5_g(input round_t r);
		logic [3:0] n;
		n = r[3:0];
		case (r[5:4])
			2'd0: md5_g = n;
			2'd1: md5_g = 4'((n << 2) + n + 4'd1);
			2'd2: md5_g = 4'((n << 1) + n + 4'd5);
			default: md5_g = 4'((n << 3) - n);
		endcase
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] y;
		y = {x, x} << n;
		return y[63:32];
	endfunction

	function automatic ctl_t md5_ucode(input step_t pc);
		ctl_t w;
		w = '0;
		case (pc)
			STEP_IDLE: begin
				w.accept = 1'b1;
				w.wop    = W_BYTE;
				w.cond   = C_STAY_IDLE;
				w.target = STEP_IDLE;
			end
			STEP_FULL_INIT: begin
				w.load_abcd = 1'b1;
				w.cond      = C_NOT_FULL;
				w.target    = STEP_PAD;
			end
			STEP_FULL_ROUND: begin
				w.round  = 1'b1;
				w.cond   = C_ROUND_MORE;
				w.target = STEP_FULL_ROUND;
			end
			STEP_FULL_ADD: begin
				w.chain_add = 1'b1;
				w.cond      = C_NOT_LAST;
				w.target    = STEP_IDLE;
			end
			STEP_PAD: begin
				w.wop       = W_PAD;
				w.load_abcd = 1'b1;
				w.cond      = C_LEN_FITS;
				w.target    = STEP_LEN;
			end
			STEP_XTRA_ROUND: begin
				w.round  = 1'b1;
				w.cond   = C_ROUND_MORE;
				w.target = STEP_XTRA_ROUND;
			end
			STEP_XTRA_ADD: begin
				w.chain_add = 1'b1;
			end
			STEP_XTRA_CLEAR: begin
				w.wop       = W_CLEAR_LEN;
				w.load_abcd = 1'b1;
				w.cond      = C_ALWAYS;
				w.target    = STEP_LAST_ROUND;
			end
			STEP_LEN: begin
				w.wop       = W_LEN;
				w.load_abcd = 1'b1;
			end
			STEP_LAST_ROUND: begin
				w.round  = 1'b1;
				w.cond   = C_ROUND_MORE;
				w.target = STEP_LAST_ROUND;
			end
			STEP_LAST_ADD: begin
				w.chain_add = 1'b1;
			end
			STEP_EMIT: begin
				w.emit   = 1'b1;
				w.cond   = C_OUT_BUSY;
				w.target = STEP_EMIT;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

@@ hw/rtl/md5_digest_engine.sv @@
// channel   dir  handshake                payload
// request   in   req_valid / req_stall    req (msg_byte, has_byte, last)
// digest    out  rsp_valid / rsp_stall    rsp (digest_low, digest_high)
//
// A request that does not complete a chunk or end the message leaves the
// engine idle. A request that completes a 64-byte chunk adds a load step, 64
// rounds, one per cycle, in the single round unit, and a chain-add step. A
// last request adds pad, length, rounds, chain-add and emit steps, and a
// second compression when it also completes a chunk or padding spills into
// a second chunk. A digest waiting under rsp_stall holds the engine at emit.
// Reset restores the initial chaining values; the chunk words are not cleared.
module md5_digest_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  md5_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output md5_pkg::rsp_t rsp
);
	import md5_pkg::*;

	step_t       pc_q;
	ctl_t        ctl;
	logic        jump;
	logic        req_take;
	logic        full_now;
	logic        out_busy;
	logic        emit_go;

	logic [31:0] words_q [16];
	logic [31:0] hash_a_q, hash_b_q, hash_c_q, hash_d_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	round_t      round_q;
	logic [63:0] msg_bits_q;
	logic [5:0]  ptr_q;
	logic        full_q;
	logic        last_q;
	logic        out_valid_q;
	rsp_t        rsp_q;

	logic [31:0] f;
	logic [31:0] t;
	logic [31:0] b_new;
	logic [3:0]  byte_w;
	logic [1:0]  byte_sh;
	logic [31:0] keep_mask;
	logic [31:0] mark_word;

	assign ctl       = md5_ucode(pc_q);
	assign req_stall = !ctl.accept;
	assign req_take  = req_valid && ctl.accept;
	assign full_now  = req.has_byte && (ptr_q == 6'd63);
	assign out_busy  = out_valid_q && rsp_stall;
	assign emit_go   = ctl.emit && !out_busy;
	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		case (ctl.cond)
			C_NEVER:      jump = 1'b0;
			C_ALWAYS:     jump = 1'b1;
			C_STAY_IDLE:  jump = !(req_take && (full_now || req.last));
			C_NOT_FULL:   jump = !full_q;
			C_ROUND_MORE: jump = (round_q != ROUND_MAX);
			C_NOT_LAST:   jump = !last_q;
			C_LEN_FITS:   jump = (ptr_q < LEN_LIMIT);
			C_OUT_BUSY:   jump = out_busy;
			default:      jump = 1'b0;
		endcase
	end

	always_comb begin
		case (round_q[5:4])
			2'd0:    f = (b_q & c_q) | (~b_q & d_q);
			2'd1:    f = (d_q & b_q) | (~d_q & c_q);
			2'd2:    f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		t     = f + a_q + K_TAB[round_q] + words_q[md5_g(round_q)];
		b_new = b_q + rotl32(t, md5_s(round_q));
	end

	assign byte_w    = ptr_q[5:2];
	assign byte_sh   = ptr_q[1:0];
	assign keep_mask = (32'h1 << {byte_sh, 3'b000}) - 32'h1;
	assign mark_word = (words_q[byte_w] & keep_mask)
		| ({24'h0, PAD_MARK} << {byte_sh, 3'b000});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_IDLE;
			hash_a_q    <= IV_A;
			hash_b_q    <= IV_B;
			hash_c_q    <= IV_C;
			hash_d_q    <= IV_D;
			msg_bits_q  <= '0;
			ptr_q       <= '0;
			full_q      <= 1'b0;
			last_q      <= 1'b0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= jump ? ctl.target : step_t'(pc_q + 4'd1);
			if (req_take) begin
				full_q <= full_now;
				last_q <= req.last;
				if (req.has_byte) begin
					msg_bits_q <= msg_bits_q + 64'd8;
					ptr_q      <= ptr_q + 6'd1;
				end
			end
			if (ctl.load_abcd) begin
				round_q <= '0;
			end else if (ctl.round) begin
				round_q <= round_q + 6'd1;
			end
			if (ctl.chain_add) begin
				hash_a_q <= hash_a_q + a_q;
				hash_b_q <= hash_b_q + b_q;
				hash_c_q <= hash_c_q + c_q;
				hash_d_q <= hash_d_q + d_q;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
				hash_a_q    <= IV_A;
				hash_b_q    <= IV_B;
				hash_c_q    <= IV_C;
				hash_d_q    <= IV_D;
				msg_bits_q  <= '0;
				ptr_q       <= '0;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_abcd) begin
			a_q <= hash_a_q;
			b_q <= hash_b_q;
			c_q <= hash_c_q;
			d_q <= hash_d_q;
		end else if (ctl.round) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_new;
		end
		if (emit_go) begin
			rsp_q.digest_low  <= {hash_b_q, hash_a_q};
			rsp_q.digest_high <= {hash_d_q, hash_c_q};
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.wop)
			W_BYTE: begin
				if (req_take && req.has_byte) begin
					if (byte_sh == 2'd0) begin
						words_q[byte_w] <= {24'h0, req.msg_byte};
					end else begin
						words_q[byte_w] <= words_q[byte_w]
							| ({24'h0, req.msg_byte} << {byte_sh, 3'b000});
					end
				end
			end
			W_PAD: begin
				for (int i = 0; i < 16; i++) begin
					if (4'(i) > byte_w) begin
						words_q[i] <= '0;
					end else if (4'(i) == byte_w) begin
						words_q[i] <= mark_word;
					end
				end
			end
			W_CLEAR_LEN: begin
				for (int i = 0; i < 14; i++) begin
					words_q[i] <= '0;
				end
				words_q[14] <= msg_bits_q[31:0];
				words_q[15] <= msg_bits_q[63:32];
			end
			W_LEN: begin
				words_q[14] <= msg_bits_q[31:0];
				words_q[15] <= msg_bits_q[63:32];
			end
			default: begin
			end
		endcase
	end

endmodule

@@ test/tb_md5_digest_engine.sv @@
module tb_md5_digest_engine;

	import md5_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 500;
	localparam int DRAIN_CYCLES = 300;
	localparam int ITEM_TARGET  = 1150;

	localparam logic [31:0] INIT_A   = 32'h67452301;
	localparam logic [31:0] INIT_B   = 32'hefcdab89;
	localparam logic [31:0] INIT_C   = 32'h98badcfe;
	localparam logic [31:0] INIT_D   = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam int          LEN_SLOT = 56;

	localparam logic [31:0] ROUND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam int ROT_AMT [16] = '{
		7, 12, 17, 22,
		5, 9, 14, 20,
		4, 11, 16, 23,
		6, 10, 15, 21
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	md5_digest_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	req_t requests_todo[$];
	rsp_t digests_due[$];

	logic [31:0] chain [4];
	logic [31:0] mix_words [16];
	logic [63:0] bit_count;
	logic [5:0]  fill_pos;

	logic req_taken = 1'b0;
	int unsigned failures = 0;
	int unsigned quiet_cycles = 0;
	int unsigned bytes_absorbed = 0;
	int unsigned markers_ignored = 0;
	int unsigned spill_digests = 0;
	int unsigned digests_checked = 0;
	int unsigned items_queued = 0;
	int unsigned messages_queued = 0;

	function automatic void load_iv();
		chain[0] = INIT_A;
		chain[1] = INIT_B;
		chain[2] = INIT_C;
		chain[3] = INIT_D;
		bit_count = '0;
		fill_pos = '0;
	endfunction

	function automatic void store_msg_byte(input logic [5:0] pos, input logic [7:0] v);
		if (pos[1:0] == 2'd0) begin
			mix_words[pos[5:2]] = '0;
		end
		mix_words[pos[5:2]][pos[1:0]*8 +: 8] = v;
	endfunction

	function automatic void compress_chunk();
		logic [31:0] a, b, c, d, f, t;
		int r, g, s;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		for (r = 0; r < 64; r++) begin
			case (r / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = r;
				end
				1: begin
					f = (d & b) | (~d & c);
					g = (5 * r + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * r + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * r) % 16;
				end
			endcase
			s = ROT_AMT[(r / 16) * 4 + (r % 4)];
			t = f + a + ROUND_K[r] + mix_words[g];
			a = d;
			d = c;
			c = b;
			b = b + ((t << s) | (t >> (32 - s)));
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
	endfunction

	function automatic void absorb_request(input req_t r);
		rsp_t digest;
		int p;
		if (r.has_byte) begin
			store_msg_byte(fill_pos, r.msg_byte);
			bit_count += 64'd8;
			fill_pos += 6'd1;
			bytes_absorbed++;
			if (fill_pos == 6'd0) begin
				compress_chunk();
			end
		end else if (!r.last) begin
			markers_ignored++;
		end
		if (r.last) begin
			store_msg_byte(fill_pos, PAD_BYTE);
			for (p = fill_pos + 1; p < 64; p++) begin
				store_msg_byte(6'(p), 8'h00);
			end
			if (fill_pos >= LEN_SLOT) begin
				spill_digests++;
				compress_chunk();
				for (p = 0; p < 64; p++) begin
					store_msg_byte(6'(p), 8'h00);
				end
			end
			mix_words[14] = bit_count[31:0];
			mix_words[15] = bit_count[63:32];
			compress_chunk();
			digest.digest_low  = {chain[1], chain[0]};
			digest.digest_high = {chain[3], chain[2]};
			digests_due = {digests_due, digest};
			load_iv();
		end
	endfunction

	function automatic void queue_request(input logic [7:0] b, input logic has, input logic fin);
		req_t r;
		r.msg_byte = b;
		r.has_byte = has;
		r.last     = fin;
		requests_todo = {requests_todo, r};
		if (has || fin) begin
			items_queued++;
		end
		if (fin) begin
			messages_queued++;
		end
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void queue_message(input int len);
		logic marker_end;
		int i;
		marker_end = (len == 0) || ($urandom_range(0, 1) == 1);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0) begin
				queue_request(pick_byte(), 1'b0, 1'b0);
			end
			queue_request(pick_byte(), 1'b1, !marker_end && (i == len - 1));
		end
		if (marker_end) begin
			queue_request(pick_byte(), 1'b0, 1'b1);
		end
	endfunction

	// offer requests in bursts separated by random gaps
	always @(negedge clk) begin : drive_requests
		int burst_left;
		int gap_left;
		logic offer;
		if (arst_n && (!req_valid || req_taken)) begin
			offer = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (requests_todo.size() > 0) begin
				offer = 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			req_valid <= offer;
			if (offer) begin
				req <= requests_todo[0];
			end
		end
	end

	// stall digests on a changing pattern, with one long hold-off
	always @(negedge clk) begin : drive_stall
		int hold_left;
		logic hold_done;
		int mode_left;
		int stall_mode;
		if (arst_n) begin
			if (mode_left <= 0) begin
				mode_left = $urandom_range(20, 80);
				stall_mode = $urandom_range(0, 3);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (!hold_done && digests_checked >= 8) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				rsp_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 1) == 1);
					2: rsp_stall <= ($urandom_range(0, 3) == 0);
					default: rsp_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= req_valid && !req_stall;
			quiet_cycles++;
			if (req_valid && !req_stall) begin
				quiet_cycles = 0;
				absorb_request(req);
				void'(requests_todo.pop_front());
			end
			if (rsp_valid && !rsp_stall) begin
				quiet_cycles = 0;
				if (digests_due.size() == 0) begin
					failures++;
					$display("%0t: unexpected digest low=%h high=%h",
						$time, rsp.digest_low, rsp.digest_high);
				end else begin
					if (rsp.digest_low !== digests_due[0].digest_low) begin
						failures++;
						$display("%0t: digest_low expected %h actual %h",
							$time, digests_due[0].digest_low, rsp.digest_low);
					end
					if (rsp.digest_high !== digests_due[0].digest_high) begin
						failures++;
						$display("%0t: digest_high expected %h actual %h",
							$time, digests_due[0].digest_high, rsp.digest_high);
					end
					void'(digests_due.pop_front());
					digests_checked++;
				end
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		int len;
		int i;
		load_iv();
		for (i = 0; i < 16; i++) begin
			mix_words[i] = '0;
		end

		// empty message, ignored marker, single bytes, two bytes with a marker between, "abc"
		queue_request(8'h00, 1'b0, 1'b1);
		queue_request(8'hff, 1'b0, 1'b0);
		queue_request(8'h00, 1'b1, 1'b1);
		queue_request(8'hff, 1'b1, 1'b1);
		queue_request(8'hff, 1'b1, 1'b0);
		queue_request(8'h80, 1'b1, 1'b0);
		queue_request(8'h5a, 1'b0, 1'b0);
		queue_request(8'h00, 1'b0, 1'b1);
		queue_request(8'h61, 1'b1, 1'b0);
		queue_request(8'h62, 1'b1, 1'b0);
		queue_request(8'h63, 1'b1, 1'b1);
		queue_request(8'hff, 1'b0, 1'b1);

		while (items_queued < ITEM_TARGET) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: len = $urandom_range(0, 20);
				12, 13, 14, 15, 16: len = $urandom_range(54, 66);
				17, 18: len = $urandom_range(110, 130);
				default: len = $urandom_range(180, 200);
			endcase
			queue_message(len);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (requests_todo.size() > 0 || digests_due.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d messages, %0d bytes, %0d ignored markers.",
			messages_queued, bytes_absorbed, markers_ignored);
		$display("Checked %0d digests, %0d with padding spilling into a second chunk.",
			digests_checked, spill_digests);
		if (failures == 0 && digests_due.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
